### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the 2x upscaler.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bu2x_pkg.sv
// Package for the 2x bilinear upscaler: sizes, register indexes and helpers.
// No dependencies; used by bilinear_upscale_2x.
package bu2x_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;
  localparam int WCMP_W       = (COL_W + 1 > 11) ? COL_W + 1 : 11;

  localparam logic [WCMP_W-1:0] MAX_WIDTH_W    = WCMP_W'(MAX_WIDTH);
  localparam logic [WCMP_W-1:0] MAX_COL_W      = WCMP_W'(MAX_WIDTH - 1);
  localparam logic [12:0]       HEIGHT_LIMIT_H = 13'(HEIGHT_LIMIT);
  localparam logic [ROW_W-1:0]  MAX_ROW        = ROW_W'(HEIGHT_LIMIT - 1);

  typedef logic [7:0] cfg_index_t;

  localparam cfg_index_t REG_IMAGE_WIDTH  = 8'd0;
  localparam cfg_index_t REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [1:0] PIX_BOTTOM_RIGHT = 2'd3;

  // Floor average of two 8-bit values over a 9-bit sum.
  function automatic logic [7:0] avg2(input logic [7:0] p, input logic [7:0] q);
    logic [8:0] sum;
    sum = {1'b0, p} + {1'b0, q};
    return sum[8:1];
  endfunction

endpackage

### rtl/bilinear_upscale_2x.sv
// Top level of the streaming 2x bilinear upscaler with its line store.
// Depends on bu2x_pkg and assert_macros.svh.
//
//  Channel  Handshake             Payload
//  -------  --------------------  --------------------------------------------
//  cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (register writes)
//  in       in_valid/in_ready     pixel
//  out      out_valid/out_ready   value, out_x, out_y, last, frame_done
//
// A pixel that completes no block sends no result; the output side sends one
// result per cycle unless out_ready stalls it, four for each completed block
// (four on average per pixel, up to sixteen for the last pixel of a frame).
// The first result passes line store read, block unit load, output register.
// Reset clears the counters and neighbour pixels; the line store needs no
// clearing pass since every entry is written a row before its value is used.
// A stalled output holds the block unit, and then the input side.
`include "assert_macros.svh"

module bilinear_upscale_2x (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  value,
  output logic [10:0] out_x,
  output logic [12:0] out_y,
  output logic        last,
  output logic        frame_done
);

  // ---------------------------------------------------------------------
  // Configuration registers. Any accepted write to a known register also
  // restarts the frame; writes to unknown indexes are dropped entirely.
  // ---------------------------------------------------------------------
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic        cfg_fire;
  logic        cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == bu2x_pkg::REG_IMAGE_WIDTH ||
                                  cfg_index == bu2x_pkg::REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd1024;
      image_height <= 13'd1024;
    end else if (cfg_fire) begin
      if (cfg_index == bu2x_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[10:0];
      end
      if (cfg_index == bu2x_pkg::REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // Index of the last column and last row, with out-of-range settings
  // clamped: zero behaves as one, large values saturate at the limits.
  logic [bu2x_pkg::WCMP_W-1:0] w_ext;
  logic [bu2x_pkg::WCMP_W-1:0] wm1_full;
  logic [bu2x_pkg::COL_W-1:0]  last_col_idx;
  logic [12:0]                 hm1_full;
  logic [bu2x_pkg::ROW_W-1:0]  last_row_idx;

  always_comb begin
    w_ext       = '0;
    w_ext[10:0] = image_width;
    priority if (image_width == 11'd0) begin
      wm1_full = '0;
    end else if (w_ext > bu2x_pkg::MAX_WIDTH_W) begin
      wm1_full = bu2x_pkg::MAX_COL_W;
    end else begin
      wm1_full = w_ext - 1'b1;
    end
    last_col_idx = wm1_full[bu2x_pkg::COL_W-1:0];

    priority if (image_height == 13'd0) begin
      hm1_full = '0;
    end else if (image_height > bu2x_pkg::HEIGHT_LIMIT_H) begin
      hm1_full = {1'b0, bu2x_pkg::MAX_ROW};
    end else begin
      hm1_full = image_height - 1'b1;
    end
    last_row_idx = hm1_full[bu2x_pkg::ROW_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Input stage: position tracking and the line store access. The store is
  // read and written at the same column in the same cycle; the read returns
  // the value left by the row above.
  // ---------------------------------------------------------------------
  logic [bu2x_pkg::COL_W-1:0] col_count;
  logic [bu2x_pkg::ROW_W-1:0] row_count;
  logic [bu2x_pkg::COL_W-1:0] c_use;
  logic [bu2x_pkg::ROW_W-1:0] r_use;
  logic                       at_last_col;
  logic                       at_last_row;
  logic [3:0]                 blk_mask;
  logic                       in_fire;

  assign c_use       = (col_count > last_col_idx) ? last_col_idx : col_count;
  assign r_use       = (row_count > last_row_idx) ? last_row_idx : row_count;
  assign at_last_col = (c_use == last_col_idx);
  assign at_last_row = (r_use == last_row_idx);

  // Blocks completed by this pixel, in sending order: upper-left, upper,
  // left, and the pixel's own block.
  assign blk_mask[0] = (r_use != '0) && (c_use != '0);
  assign blk_mask[1] = (r_use != '0) && at_last_col;
  assign blk_mask[2] = at_last_row && (c_use != '0);
  assign blk_mask[3] = at_last_row && at_last_col;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_fire) begin
      if (at_last_col) begin
        col_count <= '0;
        row_count <= at_last_row ? '0 : r_use + 1'b1;
      end else begin
        col_count <= c_use + 1'b1;
        row_count <= r_use;
      end
    end
  end

  logic [7:0] row_mem [bu2x_pkg::MAX_WIDTH];
  logic [7:0] rd_data;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      row_mem[c_use] <= pixel;
      rd_data        <= row_mem[c_use];
    end
  end

  // Stage one waits for the line store data; it holds while the block
  // unit is busy, and then the store output holds as well.
  logic                       s1_valid;
  logic [7:0]                 s1_p;
  logic [bu2x_pkg::COL_W-1:0] s1_c;
  logic [bu2x_pkg::ROW_W-1:0] s1_r;
  logic [3:0]                 s1_mask;
  logic                       s1_frame_end;
  logic                       s1_xfer;
  logic                       em_free;

  assign s1_xfer  = s1_valid && em_free;
  assign in_ready = !s1_valid || s1_xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_fire;
    end
    if (in_fire) begin
      s1_p         <= pixel;
      s1_c         <= c_use;
      s1_r         <= r_use;
      s1_mask      <= blk_mask;
      s1_frame_end <= at_last_row && at_last_col;
    end
  end

  // Neighbour pixels of the previous item, advanced as each item leaves
  // stage one.
  logic [7:0] left_pixel;
  logic [7:0] upper_left_pixel;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (s1_xfer) begin
      left_pixel       <= s1_p;
      upper_left_pixel <= rd_data;
    end
  end

  // ---------------------------------------------------------------------
  // Block unit: walks the pending blocks lowest first, four pixels each,
  // one result per cycle into the output register while that register can advance.
  // ---------------------------------------------------------------------
  logic                       em_valid;
  logic [3:0]                 em_mask;
  logic [1:0]                 em_pix;
  logic [7:0]                 em_ul;
  logic [7:0]                 em_up;
  logic [7:0]                 em_left;
  logic [7:0]                 em_p;
  logic [bu2x_pkg::COL_W-1:0] em_c;
  logic [bu2x_pkg::ROW_W-1:0] em_r;
  logic                       em_frame_end;
  logic                       out_adv;
  logic                       em_step;
  logic                       em_done;
  logic [3:0]                 sel_oh;
  logic [1:0]                 sel;

  assign out_adv = !out_valid || out_ready;
  assign em_step = em_valid && out_adv;
  assign sel_oh  = em_mask & (~em_mask + 4'd1);
  assign em_done = (em_pix == bu2x_pkg::PIX_BOTTOM_RIGHT) &&
                   ((em_mask & ~sel_oh) == 4'd0);
  assign em_free = !em_valid || (em_step && em_done);

  always_comb begin
    priority if (em_mask[0]) begin
      sel = 2'd0;
    end else if (em_mask[1]) begin
      sel = 2'd1;
    end else if (em_mask[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
      em_mask  <= '0;
      em_pix   <= '0;
    end else begin
      if (em_step) begin
        em_pix <= em_pix + 2'd1;
        if (em_pix == bu2x_pkg::PIX_BOTTOM_RIGHT) begin
          em_mask <= em_mask & ~sel_oh;
        end
        if (em_done) begin
          em_valid <= 1'b0;
        end
      end
      if (s1_xfer && s1_mask != 4'd0) begin
        em_valid <= 1'b1;
        em_mask  <= s1_mask;
        em_pix   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_xfer) begin
      em_ul        <= upper_left_pixel;
      em_up        <= rd_data;
      em_left      <= left_pixel;
      em_p         <= s1_p;
      em_c         <= s1_c;
      em_r         <= s1_r;
      em_frame_end <= s1_frame_end;
    end
  end

  // Source pixels and position of the current block. Bottom-edge blocks
  // copy the top row downwards.
  logic [7:0]                 src_a;
  logic [7:0]                 src_b;
  logic [7:0]                 src_d;
  logic [7:0]                 src_e;
  logic                       bottom_edge;
  logic [bu2x_pkg::COL_W-1:0] blk_col;
  logic [bu2x_pkg::ROW_W-1:0] blk_row;
  logic [7:0]                 top_right;
  logic [7:0]                 pix_val;
  logic [bu2x_pkg::COL_W:0]   x_full;

  always_comb begin
    unique case (sel)
      2'd0: begin
        src_a = em_ul;   src_b = em_up; src_d = em_left; src_e = em_p;
        bottom_edge = 1'b0;
        blk_col = em_c - 1'b1;
        blk_row = em_r - 1'b1;
      end
      2'd1: begin
        src_a = em_up;   src_b = em_up; src_d = em_p;    src_e = em_p;
        bottom_edge = 1'b0;
        blk_col = em_c;
        blk_row = em_r - 1'b1;
      end
      2'd2: begin
        src_a = em_left; src_b = em_p;  src_d = em_left; src_e = em_p;
        bottom_edge = 1'b1;
        blk_col = em_c - 1'b1;
        blk_row = em_r;
      end
      default: begin
        src_a = em_p;    src_b = em_p;  src_d = em_p;    src_e = em_p;
        bottom_edge = 1'b1;
        blk_col = em_c;
        blk_row = em_r;
      end
    endcase

    top_right = bu2x_pkg::avg2(src_a, src_b);
    unique case (em_pix)
      2'd0: pix_val = src_a;
      2'd1: pix_val = top_right;
      2'd2: pix_val = bottom_edge ? src_a : bu2x_pkg::avg2(src_a, src_d);
      default: pix_val = bottom_edge ? top_right :
                         bu2x_pkg::avg2(top_right, bu2x_pkg::avg2(src_d, src_e));
    endcase
    x_full = {blk_col, em_pix[0]};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= em_valid;
    end
    if (em_step) begin
      value      <= pix_val;
      out_x      <= 11'(x_full);
      out_y      <= {blk_row, em_pix[1]};
      last       <= em_done;
      frame_done <= em_done && em_frame_end;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_em_has_work, em_valid |-> em_mask != 4'd0, "block unit busy with no blocks")
  `ASSERT_CLK(a_rd_hold, s1_valid && !s1_xfer |-> !in_fire, "line store read in a stall")
  `ASSERT_CLK(a_frame_last, out_valid && frame_done |-> last, "frame end not on a last beat")
  `ASSERT_ALWAYS(a_cfg_restart, !rst && cfg_hit |=> col_count == '0 && row_count == '0,
                 "register write did not restart the frame")

endmodule
